// ===== src/asbf_pkg.sv =====
// shared types, constants and codes for the sample byte fifo
// no dependencies; used by every module of the block by scoped names
`default_nettype none

package asbf_pkg;

   // storage geometry
   localparam int STORE_DEPTH  = 512;
   localparam int PTR_W        = $clog2(STORE_DEPTH);
   localparam int RECORD_BYTES = 6;
   localparam int MAX_BATCH    = 64;
   localparam int COUNT_W      = 7;
   localparam int PEND_W       = 16;
   localparam logic [PEND_W-1:0] PENDING_MAX = '1;

   // bytes of a record held while the last one is still in the memory read register
   localparam int REC_HOLD_W   = 8 * (RECORD_BYTES - 1);
   localparam int BIDX_W       = $clog2(RECORD_BYTES);

   // pending bytes at or above this always hold a full batch
   localparam int BIG_PENDING  = MAX_BATCH * RECORD_BYTES;
   localparam int SMALL_W      = $clog2(BIG_PENDING);
   // floor(p / RECORD_BYTES) as (p * RECIP) >> RECIP_SHIFT, exact for p below BIG_PENDING
   localparam int RECIP_SHIFT  = 10;
   localparam int RECIP        = (1 << RECIP_SHIFT) / RECORD_BYTES + 1;
   localparam int RECIP_W      = $clog2(RECIP + 1);
   localparam int PROD_W       = SMALL_W + RECIP_W;

   // command queue between front and back
   localparam int QUEUE_DEPTH  = 2;
   localparam int QIDX_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   // configuration port
   localparam int CSR_ADDR_W   = 2;
   localparam int CSR_DATA_W   = 7;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_ENABLE   = 2'd0,
      CSR_MODE     = 2'd1,
      CSR_HR_BATCH = 2'd2,
      CSR_BO_BATCH = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      MODE_NONE = 2'd0,
      MODE_HR   = 2'd1,
      MODE_BO   = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_kind_type;

   typedef enum logic [1:0] {
      BK_IDLE  = 2'd0,
      BK_COUNT = 2'd1,
      BK_FETCH = 2'd2,
      BK_EMIT  = 2'd3
   } back_state_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [7:0]         data;
      logic [COUNT_W-1:0] limit;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

// ===== src/asbf_front.sv =====
// front end: configuration registers, request decode and command classification
// depends on asbf_pkg
`default_nettype none

module asbf_front (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [asbf_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire  [asbf_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [7:0]                       req_tdata,
   input  wire  [1:0]                       req_tuser,
   input  wire  asbf_pkg::queue_status_type q_status,
   output logic                             q_push,
   output asbf_pkg::cmd_type                q_cmd
);

   logic                          enable_ff, enable_in;
   logic [1:0]                    mode_ff, mode_in;
   logic [asbf_pkg::COUNT_W-1:0]  hr_batch_ff, hr_batch_in;
   logic [asbf_pkg::COUNT_W-1:0]  bo_batch_ff, bo_batch_in;
   logic [asbf_pkg::COUNT_W-1:0]  raw_limit;
   logic [asbf_pkg::COUNT_W-1:0]  sat_limit;
   logic                          active;

   assign csr_ready  = 1'b1;
   assign req_tready = !q_status.full;

   always_comb begin
      enable_in   = enable_ff;
      mode_in     = mode_ff;
      hr_batch_in = hr_batch_ff;
      bo_batch_in = bo_batch_ff;
      if (csr_valid) begin
         case (csr_addr)
            asbf_pkg::CSR_ENABLE:   enable_in   = csr_wdata[0];
            asbf_pkg::CSR_MODE:     mode_in     = csr_wdata[1:0];
            asbf_pkg::CSR_HR_BATCH: hr_batch_in = csr_wdata;
            asbf_pkg::CSR_BO_BATCH: bo_batch_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b0;
         mode_ff     <= asbf_pkg::MODE_NONE;
         hr_batch_ff <= asbf_pkg::COUNT_W'(30);
         bo_batch_ff <= asbf_pkg::COUNT_W'(30);
      end else begin
         enable_ff   <= enable_in;
         mode_ff     <= mode_in;
         hr_batch_ff <= hr_batch_in;
         bo_batch_ff <= bo_batch_in;
      end
   end

   // batch limit for the current mode, saturated to the largest batch
   always_comb begin
      case (mode_ff)
         asbf_pkg::MODE_HR: raw_limit = hr_batch_ff;
         asbf_pkg::MODE_BO: raw_limit = bo_batch_ff;
         default:           raw_limit = '0;
      endcase
      if (raw_limit > asbf_pkg::COUNT_W'(asbf_pkg::MAX_BATCH)) begin
         sat_limit = asbf_pkg::COUNT_W'(asbf_pkg::MAX_BATCH);
      end else begin
         sat_limit = raw_limit;
      end
   end

   // drop anything that cannot change state or give a result
   always_comb begin
      q_cmd.data  = req_tdata;
      q_cmd.limit = sat_limit;
      q_cmd.kind  = asbf_pkg::CMD_CLEAR;
      active      = 1'b0;
      case (req_tuser)
         asbf_pkg::OP_CLEAR: begin
            q_cmd.kind = asbf_pkg::CMD_CLEAR;
            active     = 1'b1;
         end
         asbf_pkg::OP_WRITE: begin
            q_cmd.kind = asbf_pkg::CMD_WRITE;
            active     = enable_ff;
         end
         asbf_pkg::OP_READ: begin
            q_cmd.kind = asbf_pkg::CMD_READ;
            active     = enable_ff && (sat_limit != '0);
         end
         default: ;
      endcase
      q_push = req_tvalid && req_tready && active;
   end

endmodule

`default_nettype wire

// ===== src/asbf_cmd_queue.sv =====
// short command queue that decouples the front end from the back end
// depends on asbf_pkg
`default_nettype none

module asbf_cmd_queue (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               push,
   input  wire  asbf_pkg::cmd_type           push_cmd,
   input  wire                               pop,
   output asbf_pkg::cmd_type                 head_cmd,
   output asbf_pkg::queue_status_type        status
);

   asbf_pkg::cmd_type             slot_ff [asbf_pkg::QUEUE_DEPTH];
   logic [asbf_pkg::QIDX_W-1:0]   wr_idx_ff, wr_idx_in;
   logic [asbf_pkg::QIDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [asbf_pkg::QCNT_W-1:0]   cnt_ff, cnt_in;

   function automatic logic [asbf_pkg::QIDX_W-1:0] bump(input logic [asbf_pkg::QIDX_W-1:0] i);
      if (i == asbf_pkg::QIDX_W'(asbf_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return i + 1'b1;
   endfunction

   assign head_cmd     = slot_ff[rd_idx_ff];
   assign status.full  = (cnt_ff == asbf_pkg::QCNT_W'(asbf_pkg::QUEUE_DEPTH));
   assign status.empty = (cnt_ff == '0);

   always_comb begin
      wr_idx_in = push ? bump(wr_idx_ff) : wr_idx_ff;
      rd_idx_in = pop  ? bump(rd_idx_ff) : rd_idx_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_idx_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== src/asbf_back.sv =====
// back end: byte store, pointers, pending count, record walk and result register
// depends on asbf_pkg
`default_nettype none

module asbf_back (
   input  wire                               clock,
   input  wire                               reset,
   input  wire  asbf_pkg::cmd_type           head_cmd,
   input  wire  asbf_pkg::queue_status_type  q_status,
   output logic                              q_pop,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [55:0]                       rsp_tdata,
   output logic                              rsp_tlast
);

   localparam int PW = asbf_pkg::PTR_W;
   localparam int CW = asbf_pkg::COUNT_W;
   localparam int NW = asbf_pkg::PEND_W;

   asbf_pkg::back_state_type        state_ff, state_in;
   logic [PW-1:0]                   wp_ff, wp_in;
   logic [PW-1:0]                   rp_ff, rp_in;
   logic [NW-1:0]                   pending_ff, pending_in;
   logic [CW-1:0]                   limit_ff, limit_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic [CW-1:0]                   left_ff, left_in;
   logic [asbf_pkg::BIDX_W-1:0]     bidx_ff, bidx_in;
   logic [asbf_pkg::REC_HOLD_W-1:0] rec_ff, rec_in;
   logic                            valid_ff, valid_in;
   logic [55:0]                     data_ff, data_in;
   logic                            last_ff, last_in;

   logic [7:0]                      mem_ff [asbf_pkg::STORE_DEPTH];
   logic [7:0]                      mem_q_ff;
   logic                            mem_we;
   logic                            mem_re;
   logic [PW-1:0]                   mem_addr;

   logic                            big;
   logic [asbf_pkg::PROD_W-1:0]     prod;
   logic [CW-1:0]                   avail;
   logic [CW-1:0]                   count_calc;
   logic                            slot_free;
   logic [47:0]                     record;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      if (p == PW'(asbf_pkg::STORE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   // whole records pending, only exact below the big threshold
   assign big   = (pending_ff >= NW'(asbf_pkg::BIG_PENDING));
   assign prod  = asbf_pkg::PROD_W'(pending_ff[asbf_pkg::SMALL_W-1:0])
                * asbf_pkg::PROD_W'(asbf_pkg::RECIP);
   assign avail = prod[asbf_pkg::RECIP_SHIFT +: CW];

   always_comb begin
      if (big || (avail >= limit_ff)) begin
         count_calc = limit_ff;
      end else begin
         count_calc = avail;
      end
   end

   assign slot_free = !valid_ff || rsp_tready;
   // final byte still sits in the memory read register
   assign record    = {mem_q_ff, rec_ff};

   always_comb begin
      state_in   = state_ff;
      wp_in      = wp_ff;
      rp_in      = rp_ff;
      pending_in = pending_ff;
      limit_in   = limit_ff;
      count_in   = count_ff;
      left_in    = left_ff;
      bidx_in    = bidx_ff;
      rec_in     = rec_ff;
      data_in    = data_ff;
      last_in    = last_ff;
      valid_in   = valid_ff && !rsp_tready;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_addr   = rp_ff;
      q_pop      = 1'b0;
      case (state_ff)
         asbf_pkg::BK_IDLE: begin
            if (!q_status.empty) begin
               q_pop = 1'b1;
               case (head_cmd.kind)
                  asbf_pkg::CMD_WRITE: begin
                     mem_we   = 1'b1;
                     mem_addr = wp_ff;
                     wp_in    = next_ptr(wp_ff);
                     if (pending_ff != asbf_pkg::PENDING_MAX) begin
                        pending_in = pending_ff + 1'b1;
                     end
                  end
                  asbf_pkg::CMD_CLEAR: begin
                     wp_in      = '0;
                     rp_in      = '0;
                     pending_in = '0;
                  end
                  asbf_pkg::CMD_READ: begin
                     limit_in = head_cmd.limit;
                     state_in = asbf_pkg::BK_COUNT;
                  end
                  default: ;
               endcase
            end
         end
         asbf_pkg::BK_COUNT: begin
            if (count_calc == '0) begin
               state_in = asbf_pkg::BK_IDLE;
            end else begin
               count_in = count_calc;
               left_in  = count_calc;
               bidx_in  = '0;
               state_in = asbf_pkg::BK_FETCH;
            end
         end
         asbf_pkg::BK_FETCH: begin
            mem_re = 1'b1;
            rp_in  = next_ptr(rp_ff);
            if (bidx_ff != '0) begin
               rec_in = {mem_q_ff, rec_ff[asbf_pkg::REC_HOLD_W-1:8]};
            end
            if (bidx_ff == asbf_pkg::BIDX_W'(asbf_pkg::RECORD_BYTES - 1)) begin
               state_in = asbf_pkg::BK_EMIT;
            end else begin
               bidx_in = bidx_ff + 1'b1;
            end
         end
         asbf_pkg::BK_EMIT: begin
            if (slot_free) begin
               valid_in   = 1'b1;
               data_in    = {1'b0, count_ff, record};
               last_in    = (left_ff == CW'(1));
               pending_in = pending_ff - NW'(asbf_pkg::RECORD_BYTES);
               left_in    = left_ff - 1'b1;
               bidx_in    = '0;
               if (left_ff == CW'(1)) begin
                  state_in = asbf_pkg::BK_IDLE;
               end else begin
                  state_in = asbf_pkg::BK_FETCH;
               end
            end
         end
         default: state_in = asbf_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= asbf_pkg::BK_IDLE;
         wp_ff      <= '0;
         rp_ff      <= '0;
         pending_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wp_ff      <= wp_in;
         rp_ff      <= rp_in;
         pending_ff <= pending_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      limit_ff <= limit_in;
      count_ff <= count_in;
      left_ff  <= left_in;
      bidx_ff  <= bidx_in;
      rec_ff   <= rec_in;
      data_ff  <= data_in;
      last_ff  <= last_in;
   end

   // single-port byte store with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_addr] <= head_cmd.data;
      end
      if (mem_re) begin
         mem_q_ff <= mem_ff[mem_addr];
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

// ===== src/accel_sample_byte_fifo_core.sv =====
// top level of the accelerometer sample byte fifo: front end, command queue, back end
// depends on asbf_pkg, asbf_front, asbf_cmd_queue and asbf_back
//
// req channel: one transaction per command; tuser carries the opcode (write a byte,
//   read a batch, clear), tdata the byte to store, tlast marks the end of a write
//   burst and has no effect on storage
// rsp channel: one transaction per 6-byte record, three signed little-endian axes,
//   the batch record count and tlast on the final record of the batch
// csr channel: register writes by index (enable, mode, two batch limits), always
//   ready; registers are only to be written while the block is idle
// back end: a write or a clear is handled in the idle state; a read first sizes the
//   batch and then walks each record as six byte fetches through the single-port
//   byte store followed by a load of the result register
// a read taken by an idle back end passes the command queue, the sizing state, the
//   byte fetches and the result register before its first record comes out
// a two-entry command queue lets requests be taken while a read is being walked;
//   req_tready drops only when that queue is full
// when the receiver stalls the record waits in the result register and the walk
//   pauses before the next record, so nothing is lost or repeated
// reset clears the pointers, the pending count, the queue, the configuration registers
//   and the result valid flag; the byte store is not cleared and needs no clearing pass
`default_nettype none

module accel_sample_byte_fifo_core (
   input  wire                              clock,
   input  wire                              reset,
   // configuration write channel
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [asbf_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire  [asbf_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // request channel
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [7:0]                       req_tdata,   // [7:0] data_byte
   input  wire  [1:0]                       req_tuser,   // [1:0] opcode
   input  wire                              req_tlast,   // burst_last
   // result channel
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [55:0]                      rsp_tdata,   // [15:0] x_axis, [31:16] y_axis,
                                                         // [47:32] z_axis,
                                                         // [54:48] record_count, [55] zero
   output logic                             rsp_tlast    // last_record
);

   // handshake signals between the parts
   logic                        q_push;
   logic                        q_pop;
   asbf_pkg::cmd_type           q_cmd;
   asbf_pkg::cmd_type           head_cmd;
   asbf_pkg::queue_status_type  q_status;
   logic                        burst_seen;

   // burst marker travels with the transaction but changes nothing
   assign burst_seen = req_tlast;

   asbf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_cmd      (q_cmd)
   );

   asbf_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   asbf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .q_status   (q_status),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // the front end never pushes into a full queue
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_status.full)
      else $error("command pushed into a full queue");

   // the back end only takes a command that is there
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_status.empty)
      else $error("command popped from an empty queue");

   // every record carries a batch size between one and the largest batch
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[54:48] != '0) &&
                     (rsp_tdata[54:48] <= asbf_pkg::COUNT_W'(asbf_pkg::MAX_BATCH)))
      else $error("record count out of range");

   // with req_tlast low, a non-last record taken and one right after share a batch size
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast && !burst_seen) |=>
         !rsp_tvalid || (rsp_tdata[54:48] == $past(rsp_tdata[54:48])))
      else $error("batch size changed within a batch");

endmodule

`default_nettype wire
